// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the range fold block.
// Stand-alone header: no dependencies; each macro expands to one labeled assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define STF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define STF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== rtl/core/stf_pkg.sv =====
// Package for the segment tree range fold block: sizes, codes, node type and combine rules.
// No dependencies; imported by every module of the block but the generic RAM stf_ram.
`timescale 1ns / 1ps

package stf_pkg;

    localparam int MAX_LEAVES  = 1024;
    localparam int LEAF_CNT_W  = $clog2(MAX_LEAVES + 1);
    localparam int POS_W       = $clog2(MAX_LEAVES);
    localparam int NODE_DEPTH  = 2 * MAX_LEAVES;
    localparam int NODE_ADDR_W = $clog2(NODE_DEPTH);
    localparam int SPAN_W      = NODE_ADDR_W + 1;
    localparam int VALUE_W     = 64;
    localparam int TAG_W       = 11;
    localparam int LEAF_TAG_W  = 10;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 11;
    localparam int NODE_W      = VALUE_W + TAG_W;

    localparam logic [TAG_W-1:0] NO_TAG = '1;

    typedef enum logic [MODE_W-1:0] {
        MODE_SUM     = 2'd0,
        MODE_MIN     = 2'd1,
        MODE_MAX     = 2'd2,
        MODE_MIN_TAG = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MODE   = 1'b0,
        CFG_LEAVES = 1'b1
    } cfg_idx_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [TAG_W-1:0]   tag;
    } node_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;
        logic load;
        logic upd_leaf;
        logic upd_step;
        logic qry_step;
        logic qry_fin;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic item_err;
        logic leaf_is_root;
        logic parent_is_root;
        logic qry_end;
    } sts_t;

    function automatic node_t identity_node(input mode_t mode);
        node_t o;
        o.tag = NO_TAG;
        unique case (mode)
            MODE_SUM:     o.value = '0;
            MODE_MAX:     o.value = {1'b1, {(VALUE_W-1){1'b0}}};
            MODE_MIN,
            MODE_MIN_TAG: o.value = {1'b0, {(VALUE_W-1){1'b1}}};
            default:      o.value = '0;
        endcase
        return o;
    endfunction

    // Combines a left operand with a right operand; ties in the tagged minimum go right.
    function automatic node_t combine(input mode_t mode, input node_t a, input node_t b);
        node_t o;
        logic  a_lt_b;
        logic  b_lt_a;
        a_lt_b  = $signed(a.value) < $signed(b.value);
        b_lt_a  = $signed(b.value) < $signed(a.value);
        o.value = a.value;
        o.tag   = NO_TAG;
        unique case (mode)
            MODE_SUM:     o.value = a.value + b.value;
            MODE_MIN:     o.value = b_lt_a ? b.value : a.value;
            MODE_MAX:     o.value = a_lt_b ? b.value : a.value;
            MODE_MIN_TAG: o = a_lt_b ? a : b;
            default:      o.value = a.value;
        endcase
        return o;
    endfunction

endpackage

// ===== rtl/core/segment_tree_range_fold.sv =====
// Top level of the segment tree range fold block: controller plus datapath.
// Depends on stf_pkg, stf_ctrl, stf_dp and (through the datapath) stf_ram.
`timescale 1ns / 1ps

// Usage
// An item is taken on a rising edge where start is high and busy is low. With op
// low it is a point update of leaf position to (leaf_value, leaf_tag); with op high
// it folds the leaves in [range_left, range_right) with the configured rule.
// Each item yields one result beat: done is high for exactly one cycle while
// result_value, result_tag and status hold the answer. The receiver cannot stall,
// so that beat must be taken when it shows.
// A range or position error skips the level walk and goes straight to the result
// beat. After the beat the block returns to idle, where the next item can be taken.
// One item is in flight at a time; the loop is the walk over tree levels, one level
// per cycle, paced by the registered read of the node memory.
// Reset and every write to combine_mode or leaves_in_use start a clearing pass that
// sets all 2048 nodes to the identity of the mode, one node a cycle; busy stays high
// for the whole pass and register writes are still taken during the pass.

module segment_tree_range_fold (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 op,
    input  logic [stf_pkg::POS_W-1:0]            position,
    input  logic signed [stf_pkg::VALUE_W-1:0]   leaf_value,
    input  logic [stf_pkg::LEAF_TAG_W-1:0]       leaf_tag,
    input  logic [stf_pkg::LEAF_CNT_W-1:0]       range_left,
    input  logic [stf_pkg::LEAF_CNT_W-1:0]       range_right,
    output logic                                 done,
    output logic signed [stf_pkg::VALUE_W-1:0]   result_value,
    output logic signed [stf_pkg::TAG_W-1:0]     result_tag,
    output logic                                 status,
    input  logic                                 cfg_we,
    input  logic [stf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [stf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    import stf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // The controller only starts an item from idle; busy covers the clear pass too.
    stf_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .cfg_we (cfg_we),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    // The datapath owns the registers, the node memory and the result beat.
    stf_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .position     (position),
        .leaf_value   (leaf_value),
        .leaf_tag     (leaf_tag),
        .range_left   (range_left),
        .range_right  (range_right),
        .cmd          (cmd),
        .sts          (sts),
        .result_value (result_value),
        .result_tag   (result_tag),
        .status       (status)
    );

endmodule

// ===== rtl/core/stf_ram.sv =====
// Generic RAM: one write port and two read ports, read data registered.
// No dependencies; sized by its width and depth parameters.
`timescale 1ns / 1ps

module stf_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [DATA_W-1:0]          wdata,
    input  logic [$clog2(DEPTH)-1:0]   raddr_a,
    output logic [DATA_W-1:0]          rdata_a,
    input  logic [$clog2(DEPTH)-1:0]   raddr_b,
    output logic [DATA_W-1:0]          rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== rtl/core/stf_ctrl.sv =====
// Controller of the range fold block: sequences the clear pass, updates and queries.
// Depends on stf_pkg for the command and status structs.
`timescale 1ns / 1ps

module stf_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          op,
    input  logic          cfg_we,
    input  stf_pkg::sts_t sts,
    output stf_pkg::cmd_t cmd,
    output logic          busy,
    output logic          done
);

    import stf_pkg::*;

    typedef enum logic [6:0] {
        S_CLEAR    = 7'b0000001,
        S_IDLE     = 7'b0000010,
        S_UPD_LEAF = 7'b0000100,
        S_UPD_LVL  = 7'b0001000,
        S_QRY_LVL  = 7'b0010000,
        S_QRY_FIN  = 7'b0100000,
        S_RESP     = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (sts.item_err)
                    begin
                        state_next = S_RESP;
                    end
                    else if (op)
                    begin
                        state_next = S_QRY_LVL;
                    end
                    else
                    begin
                        state_next = S_UPD_LEAF;
                    end
                end
            end
            S_UPD_LEAF:
            begin
                cmd.upd_leaf = 1'b1;
                state_next   = sts.leaf_is_root ? S_RESP : S_UPD_LVL;
            end
            S_UPD_LVL:
            begin
                cmd.upd_step = 1'b1;
                if (sts.parent_is_root)
                begin
                    state_next = S_RESP;
                end
            end
            S_QRY_LVL:
            begin
                cmd.qry_step = 1'b1;
                if (sts.qry_end)
                begin
                    state_next = S_QRY_FIN;
                end
            end
            S_QRY_FIN:
            begin
                cmd.qry_fin = 1'b1;
                state_next  = S_RESP;
            end
            S_RESP:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
        // A register write starts a fresh clear pass from any state.
        if (cfg_we)
        begin
            state_next = S_CLEAR;
            cmd.load   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE) || cfg_we;
    assign done = (state_reg == S_RESP);

endmodule

// ===== rtl/core/stf_dp.sv =====
// Datapath of the range fold block: registers, node memory, combine logic and result.
// Depends on stf_pkg and the generic RAM stf_ram.
`timescale 1ns / 1ps

module stf_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [stf_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [stf_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic                                 op,
    input  logic [stf_pkg::POS_W-1:0]            position,
    input  logic signed [stf_pkg::VALUE_W-1:0]   leaf_value,
    input  logic [stf_pkg::LEAF_TAG_W-1:0]       leaf_tag,
    input  logic [stf_pkg::LEAF_CNT_W-1:0]       range_left,
    input  logic [stf_pkg::LEAF_CNT_W-1:0]       range_right,
    input  stf_pkg::cmd_t                        cmd,
    output stf_pkg::sts_t                        sts,
    output logic signed [stf_pkg::VALUE_W-1:0]   result_value,
    output logic signed [stf_pkg::TAG_W-1:0]     result_tag,
    output logic                                 status
);

    import stf_pkg::*;

    mode_t                   mode_reg,    mode_next;
    logic [LEAF_CNT_W-1:0]   nleaf_reg,   nleaf_next;
    logic [NODE_ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic                    pend_l_reg,  pend_l_next;
    logic                    pend_r_reg,  pend_r_next;
    logic [NODE_ADDR_W-1:0]  k_reg,       k_next;
    node_t                   carry_reg,   carry_next;
    logic [SPAN_W-1:0]       l_reg,       l_next;
    logic [SPAN_W-1:0]       r_reg,       r_next;
    node_t                   lacc_reg,    lacc_next;
    node_t                   racc_reg,    racc_next;
    logic [VALUE_W-1:0]      res_value_reg, res_value_next;
    logic [TAG_W-1:0]        res_tag_reg,   res_tag_next;
    logic                    status_reg,    status_next;

    logic [CFG_DATA_W-1:0]   cfg_leaves;
    logic [LEAF_CNT_W-1:0]   pos_ext;
    logic                    upd_err;
    logic                    qry_err;
    logic                    span_live;
    logic [SPAN_W-1:0]       r_dec;
    node_t                   rd_a;
    node_t                   rd_b;
    node_t                   step_node;
    node_t                   fin_node;
    logic                    mem_we;
    logic [NODE_ADDR_W-1:0]  mem_waddr;
    node_t                   mem_wdata;
    logic [NODE_ADDR_W-1:0]  raddr_a;
    logic [NODE_ADDR_W-1:0]  raddr_b;

    // Leaf count is clamped into the supported range.
    always_comb
    begin
        cfg_leaves = cfg_data;
        if (cfg_data == '0)
        begin
            cfg_leaves = CFG_DATA_W'(1);
        end
        else if (cfg_data > CFG_DATA_W'(MAX_LEAVES))
        begin
            cfg_leaves = CFG_DATA_W'(MAX_LEAVES);
        end
    end

    assign pos_ext   = LEAF_CNT_W'(position);
    assign upd_err   = pos_ext >= nleaf_reg;
    assign qry_err   = (range_left > nleaf_reg) || (range_right > nleaf_reg);
    assign span_live = l_reg < r_reg;
    assign r_dec     = r_reg - SPAN_W'(1);

    assign sts.clr_last       = (clr_cnt_reg == NODE_ADDR_W'(NODE_DEPTH - 1));
    assign sts.item_err       = op ? qry_err : upd_err;
    assign sts.leaf_is_root   = (k_reg == NODE_ADDR_W'(1));
    assign sts.parent_is_root = (k_reg[NODE_ADDR_W-1:1] == (NODE_ADDR_W-1)'(1));
    assign sts.qry_end        = !span_live;

    // The carried node is the left child when its index is even.
    assign step_node = k_reg[0] ? combine(mode_reg, rd_a, carry_reg)
                                : combine(mode_reg, carry_reg, rd_a);
    assign fin_node  = combine(mode_reg, lacc_reg, racc_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        nleaf_next     = nleaf_reg;
        clr_cnt_next   = clr_cnt_reg;
        pend_l_next    = pend_l_reg;
        pend_r_next    = pend_r_reg;
        k_next         = k_reg;
        carry_next     = carry_reg;
        l_next         = l_reg;
        r_next         = r_reg;
        lacc_next      = lacc_reg;
        racc_next      = racc_reg;
        res_value_next = res_value_reg;
        res_tag_next   = res_tag_reg;
        status_next    = status_reg;

        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MODE:   mode_next  = mode_t'(cfg_data[MODE_W-1:0]);
                CFG_LEAVES: nleaf_next = LEAF_CNT_W'(cfg_leaves);
                default:    mode_next  = mode_reg;
            endcase
            clr_cnt_next = '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_next = clr_cnt_reg + NODE_ADDR_W'(1);
        end

        if (cmd.load)
        begin
            k_next         = NODE_ADDR_W'(pos_ext + nleaf_reg);
            carry_next     = '{value: leaf_value, tag: TAG_W'(leaf_tag)};
            l_next         = SPAN_W'(range_left) + SPAN_W'(nleaf_reg);
            r_next         = SPAN_W'(range_right) + SPAN_W'(nleaf_reg);
            lacc_next      = identity_node(mode_reg);
            racc_next      = identity_node(mode_reg);
            pend_l_next    = 1'b0;
            pend_r_next    = 1'b0;
            res_value_next = '0;
            res_tag_next   = NO_TAG;
            status_next    = sts.item_err;
        end

        if (cmd.upd_step)
        begin
            carry_next = step_node;
            k_next     = k_reg >> 1;
        end

        if (cmd.qry_step)
        begin
            if (pend_l_reg)
            begin
                lacc_next = combine(mode_reg, lacc_reg, rd_a);
            end
            if (pend_r_reg)
            begin
                racc_next = combine(mode_reg, rd_b, racc_reg);
            end
            if (span_live)
            begin
                pend_l_next = l_reg[0];
                pend_r_next = r_reg[0];
                l_next      = (l_reg + SPAN_W'(l_reg[0])) >> 1;
                r_next      = (r_reg - SPAN_W'(r_reg[0])) >> 1;
            end
            else
            begin
                pend_l_next = 1'b0;
                pend_r_next = 1'b0;
            end
        end

        if (cmd.qry_fin)
        begin
            res_value_next = fin_node.value;
            res_tag_next   = (mode_reg == MODE_MIN_TAG) ? fin_node.tag : NO_TAG;
        end
    end

    // Memory port steering.
    always_comb
    begin
        mem_we    = cmd.clr_step || cmd.upd_leaf || cmd.upd_step;
        mem_waddr = clr_cnt_reg;
        mem_wdata = identity_node(mode_reg);
        if (cmd.upd_leaf)
        begin
            mem_waddr = k_reg;
            mem_wdata = carry_reg;
        end
        else if (cmd.upd_step)
        begin
            mem_waddr = k_reg >> 1;
            mem_wdata = step_node;
        end

        if (cmd.qry_step)
        begin
            raddr_a = l_reg[NODE_ADDR_W-1:0];
        end
        else if (cmd.upd_step)
        begin
            raddr_a = (k_reg >> 1) ^ NODE_ADDR_W'(1);
        end
        else
        begin
            raddr_a = k_reg ^ NODE_ADDR_W'(1);
        end
        raddr_b = r_dec[NODE_ADDR_W-1:0];
    end

    stf_ram #(
        .DATA_W (NODE_W),
        .DEPTH  (NODE_DEPTH)
    ) u_node_ram (
        .clk     (clk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .raddr_a (raddr_a),
        .rdata_a (rd_a),
        .raddr_b (raddr_b),
        .rdata_b (rd_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_SUM;
            nleaf_reg   <= LEAF_CNT_W'(MAX_LEAVES);
            clr_cnt_reg <= '0;
            pend_l_reg  <= 1'b0;
            pend_r_reg  <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            nleaf_reg   <= nleaf_next;
            clr_cnt_reg <= clr_cnt_next;
            pend_l_reg  <= pend_l_next;
            pend_r_reg  <= pend_r_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg         <= k_next;
        carry_reg     <= carry_next;
        l_reg         <= l_next;
        r_reg         <= r_next;
        lacc_reg      <= lacc_next;
        racc_reg      <= racc_next;
        res_value_reg <= res_value_next;
        res_tag_reg   <= res_tag_next;
        status_reg    <= status_next;
    end

    assign result_value = $signed(res_value_reg);
    assign result_tag   = $signed(res_tag_reg);
    assign status       = status_reg;

endmodule

// ===== rtl/core/stf_check.sv =====
// Port-level checker for the segment tree range fold block, bound to the top level.
// Depends on stf_pkg and the macros in assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module stf_check (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 start,
    input logic                                 busy,
    input logic                                 done,
    input logic                                 status,
    input logic signed [stf_pkg::VALUE_W-1:0]   result_value,
    input logic signed [stf_pkg::TAG_W-1:0]     result_tag,
    input logic                                 cfg_we
);

    import stf_pkg::*;

    // A taken item keeps the block busy on the next cycle.
    `STF_ASSERT_NEXT(a_take_busy, clk, rst_n, start && !busy, busy)
    // A result beat lasts a single cycle.
    `STF_ASSERT_NEXT(a_done_single, clk, rst_n, done, !done)
    // The block still reports busy while a result beat is shown.
    `STF_ASSERT_NOW(a_done_busy, clk, rst_n, done, busy)
    // An error beat carries a zero value and no tag.
    `STF_ASSERT_NOW(a_err_payload, clk, rst_n, done && status, (result_value == '0) && (result_tag == $signed(NO_TAG)))
    // A register write starts a clearing pass.
    `STF_ASSERT_NEXT(a_cfg_clear, clk, rst_n, cfg_we, busy && !done)

endmodule

bind segment_tree_range_fold stf_check u_stf_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .result_value (result_value),
    .result_tag   (result_tag),
    .cfg_we       (cfg_we)
);
